// ===== sv/assert_macros.svh =====
// Assertion macros used by the key matrix change detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/kmcd_pkg.sv =====
// Shared types and constants of the key matrix change detector.
package kmcd_pkg;

    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int MAP_W     = 16;
    localparam int ROW_CNT_W = 4;
    localparam int COL_CNT_W = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 4'd1;

    localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = 4'd8;
    localparam logic [COL_CNT_W-1:0] COL_COUNT_RST = 5'd16;

    // One scanned row that has at least one changed key.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [MAP_W-1:0] change;
        logic [MAP_W-1:0] closed;
    } t_scan;

endpackage

// ===== sv/kmcd_ifs.sv =====
// Valid/ready channel interfaces of the key matrix change detector.
interface kmcd_sample_if;
    import kmcd_pkg::*;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_index;
    logic [MAP_W-1:0] col_levels;
    modport source (output valid, output row_index, output col_levels, input ready);
    modport sink   (input valid, input row_index, input col_levels, output ready);
endinterface

interface kmcd_event_if;
    import kmcd_pkg::*;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] event_row;
    logic [COL_W-1:0] event_col;
    logic             pressed;
    logic             last_event;
    modport source (output valid, output event_row, output event_col, output pressed,
                    output last_event, input ready);
    modport sink   (input valid, input event_row, input event_col, input pressed,
                    input last_event, output ready);
endinterface

interface kmcd_cfg_if;
    import kmcd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/kmcd_lane.sv =====
// One column lane: compares the sampled level with the held bit.
module kmcd_lane (
    input  logic i_en,
    input  logic i_level,
    input  logic i_held,
    output logic o_change,
    output logic o_closed,
    output logic o_held_next
);
    // A low level means the key is closed; a change is closed differing from held.
    assign o_closed    = ~i_level;
    assign o_change    = i_en & (o_closed ^ i_held);
    assign o_held_next = o_change ? o_closed : i_held;
endmodule

// ===== sv/kmcd_merge.sv =====
// Merging stage: turns a row's change vector into events, lowest column first.
module kmcd_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  kmcd_pkg::t_scan       i_scan,
    output logic                  o_can_take,
    kmcd_event_if.source          o_event
);
    import kmcd_pkg::*;
    `include "assert_macros.svh"

    logic             r_pend_valid;
    logic [ROW_W-1:0] r_pend_row;
    logic [MAP_W-1:0] r_pend_change;
    logic [MAP_W-1:0] r_pend_closed;

    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_col;
    logic             r_out_pressed;
    logic             r_out_last;

    logic [MAP_W-1:0] pick;
    logic [MAP_W-1:0] n_change;
    logic [COL_W-1:0] pick_col;
    logic             pick_last;
    logic             load_out;

    // Isolate the lowest pending column and encode its number.
    always_comb begin
        pick     = r_pend_change & (~r_pend_change + 1'b1);
        n_change = r_pend_change & ~pick;
        pick_col = '0;
        for (int k = 0; k < MAP_W; k++) begin
            if (pick[k]) begin
                pick_col = pick_col | COL_W'(k);
            end
        end
        pick_last = (n_change == '0);
    end

    assign load_out   = r_pend_valid && (!r_out_valid || o_event.ready);
    assign o_can_take = !r_pend_valid || (load_out && pick_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_load) begin
            r_pend_valid <= 1'b1;
        end else if (load_out && pick_last) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pend_row    <= i_scan.row;
            r_pend_change <= i_scan.change;
            r_pend_closed <= i_scan.closed;
        end else if (load_out) begin
            r_pend_change <= n_change;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_row     <= r_pend_row;
            r_out_col     <= pick_col;
            r_out_pressed <= |(pick & r_pend_closed);
            r_out_last    <= pick_last;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_row  = r_out_row;
    assign o_event.event_col  = r_out_col;
    assign o_event.pressed    = r_out_pressed;
    assign o_event.last_event = r_out_last;

    `ASSERT_IMPL(a_pend_nonempty, i_clk, i_rst_n, r_pend_valid, r_pend_change != '0)
    `ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, i_load, o_can_take)
    `ASSERT_NEXT(a_more_follow, i_clk, i_rst_n, load_out && !pick_last, r_pend_valid)
    `ASSERT_NEXT(a_last_sent, i_clk, i_rst_n, load_out && pick_last && !i_load, !r_pend_valid)
endmodule

// ===== sv/key_matrix_change_detector.sv =====
// Top level of the key matrix change detector.
// Each accepted row sample is compared with that row's pressed-key bitmap by one
// lane per column in the accept cycle, and the bitmap is updated in the same cycle,
// so samples of the same row may follow one another directly. A sample with no
// change, or with a row outside the rows in use, gives no event. A sample with n
// changed keys gives n events, at most 16, one per cycle while the event sink is
// ready, from a single output register in ascending column order; the next sample
// is taken in the cycle in which the last event of the previous one enters the
// output register. The bitmap is cleared by reset. Configuration writes are always
// taken; unknown register indexes are ignored.
module key_matrix_change_detector #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kmcd_sample_if.sink   i_sample,
    kmcd_event_if.source  o_event,
    kmcd_cfg_if.sink      i_cfg
);
    import kmcd_pkg::*;

    localparam int MAP_DEPTH = (ROWS < (1 << ROW_W)) ? ROWS : (1 << ROW_W);
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int COL_LIM   = (COLS < MAP_W) ? COLS : MAP_W;

    logic [ROW_CNT_W-1:0] r_row_count;
    logic [COL_CNT_W-1:0] r_col_count;
    logic [MAP_W-1:0]     r_map [MAP_DEPTH];

    logic             accept;
    logic             row_ok;
    logic             can_take;
    logic [MAP_W-1:0] held;
    logic [MAP_W-1:0] change;
    logic [MAP_W-1:0] closed;
    logic [MAP_W-1:0] n_map;
    t_scan            scan;

    assign accept = i_sample.valid && i_sample.ready;
    assign row_ok = ({1'b0, i_sample.row_index} < r_row_count)
                 && (32'(i_sample.row_index) < ROWS);
    assign held   = row_ok ? r_map[i_sample.row_index[MAP_AW-1:0]] : '0;

    for (genvar j = 0; j < MAP_W; j++) begin : g_lane
        logic en;
        assign en = (j < COL_LIM) && (COL_CNT_W'(j) < r_col_count) && row_ok;
        kmcd_lane u_lane (
            .i_en        (en),
            .i_level     (i_sample.col_levels[j]),
            .i_held      (held[j]),
            .o_change    (change[j]),
            .o_closed    (closed[j]),
            .o_held_next (n_map[j])
        );
    end

    assign scan.row    = i_sample.row_index;
    assign scan.change = change;
    assign scan.closed = closed;

    kmcd_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && (change != '0)),
        .i_scan     (scan),
        .o_can_take (can_take),
        .o_event    (o_event)
    );

    assign i_sample.ready = can_take;
    assign i_cfg.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RST;
            r_col_count <= COL_COUNT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ROW_COUNT: r_row_count <= i_cfg.data[ROW_CNT_W-1:0];
                CFG_COL_COUNT: r_col_count <= i_cfg.data[COL_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAP_DEPTH; r++) begin
                r_map[r] <= '0;
            end
        end else if (accept && row_ok) begin
            r_map[i_sample.row_index[MAP_AW-1:0]] <= n_map;
        end
    end
endmodule

// ===== tb/sv/tb_key_matrix_change_detector.sv =====
// Self-checking testbench of the key matrix change detector: directed and random row scans.
module tb_key_matrix_change_detector;
    timeunit 1ns;
    timeprecision 1ps;
    import kmcd_pkg::*;

    localparam int NUM_ROWS       = 8;
    localparam int NUM_COLS       = 16;
    localparam int RANDOM_ITEMS   = 420;
    localparam int RANDOM_PHASES  = 7;
    localparam int SETTLE_CYCLES  = 24;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int REPORT_LIMIT   = 40;

    // Register indexes that map to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             pressed;
        logic             last_event;
    } key_event_t;

    logic clk;
    logic rst_n;

    kmcd_sample_if sample_ch ();
    kmcd_event_if  event_ch ();
    kmcd_cfg_if    cfg_ch ();

    key_matrix_change_detector #(
        .ROWS(NUM_ROWS),
        .COLS(NUM_COLS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_sample(sample_ch.sink),
        .o_event (event_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Copy of the key state and the count registers.
    logic [MAP_W-1:0]     held_keys [NUM_ROWS];
    logic [ROW_CNT_W-1:0] row_count_reg;
    logic [COL_CNT_W-1:0] col_count_reg;
    key_event_t           expected_key_events [$];

    int     mismatches = 0;
    longint cycles     = 0;
    bit     steady     = 1'b0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Works out the events of one accepted row sample and updates the key state.
    function automatic void predict_key_changes(input logic [ROW_W-1:0] row,
                                                input logic [MAP_W-1:0] levels);
        int               rows_used;
        int               cols_used;
        logic [MAP_W-1:0] map;
        key_event_t       found [$];
        key_event_t       ev;
        rows_used = (row_count_reg < NUM_ROWS) ? int'(row_count_reg) : NUM_ROWS;
        cols_used = (col_count_reg < NUM_COLS) ? int'(col_count_reg) : NUM_COLS;
        if (row >= rows_used)
            return;
        map = held_keys[row];
        for (int j = 0; j < cols_used; j++) begin
            // A low level is a closed key, so equal bits mean the key changed.
            if (levels[j] == map[j]) begin
                map[j]        = ~levels[j];
                ev.row        = row;
                ev.col        = COL_W'(j);
                ev.pressed    = ~levels[j];
                ev.last_event = 1'b0;
                found.push_back(ev);
            end
        end
        held_keys[row] = map;
        for (int k = 0; k < found.size(); k++) begin
            ev            = found[k];
            ev.last_event = (k == found.size() - 1);
            expected_key_events.push_back(ev);
        end
    endfunction

    task automatic send_sample(input logic [ROW_W-1:0] row, input logic [MAP_W-1:0] levels);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0) begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid      = 1'b1;
        sample_ch.row_index  = row;
        sample_ch.col_levels = levels;
        do @(posedge clk); while (!sample_ch.ready);
        predict_key_changes(row, levels);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_ROW_COUNT: row_count_reg = value[ROW_CNT_W-1:0];
            CFG_COL_COUNT: col_count_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Stops the sample requests and lets the block finish its last row.
    task automatic wait_idle();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (expected_key_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Event sink: draws a stall before each event it takes, none in steady phases.
    initial begin
        int stall;
        event_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                event_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            event_ch.ready = 1'b1;
            do @(posedge clk); while (!(event_ch.valid && rst_n));
        end
    end

    always @(posedge clk) begin
        key_event_t got;
        key_event_t want;
        if (rst_n && event_ch.valid && event_ch.ready) begin
            got.row        = event_ch.event_row;
            got.col        = event_ch.event_col;
            got.pressed    = event_ch.pressed;
            got.last_event = event_ch.last_event;
            if (expected_key_events.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected event: row %0d col %0d pressed %0b last %0b",
                             $time, got.row, got.col, got.pressed, got.last_event);
            end else begin
                want = expected_key_events.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t: event mismatch: expected row %0d col %0d pressed %0b",
                                  " last %0b, actual row %0d col %0d pressed %0b last %0b"},
                                 $time, want.row, want.col, want.pressed, want.last_event,
                                 got.row, got.col, got.pressed, got.last_event);
                end
            end
        end
    end

    task automatic test_default_scan();
        send_sample(3'd0, 16'h0000);
        send_sample(3'd0, 16'h0000);
        send_sample(3'd0, 16'hFFFF);
        send_sample(3'd7, 16'h7FFE);
        send_sample(3'd7, 16'hFFFF);
        send_sample(3'd5, 16'hAAAA);
        send_sample(3'd5, 16'h5555);
        send_sample(3'd5, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_row_count();
        write_register(CFG_ROW_COUNT, 5'd1);
        send_sample(3'd1, 16'h0F0F);
        send_sample(3'd0, 16'h0F0F);
        wait_idle();
        // A row count of zero drops every row.
        write_register(CFG_ROW_COUNT, 5'd0);
        send_sample(3'd0, 16'hFFFF);
        wait_idle();
        // Only the low four bits land; fifteen rows clamp to the eight that exist.
        write_register(CFG_ROW_COUNT, 5'h1F);
        send_sample(3'd7, 16'h00FF);
        send_sample(3'd0, 16'hFFFF);
        wait_idle();
        write_register(CFG_ROW_COUNT, 5'd8);
    endtask

    task automatic test_col_count();
        write_register(CFG_COL_COUNT, 5'd1);
        send_sample(3'd2, 16'h0000);
        wait_idle();
        write_register(CFG_COL_COUNT, 5'd0);
        send_sample(3'd2, 16'hFFFF);
        wait_idle();
        write_register(CFG_COL_COUNT, 5'd31);
        send_sample(3'd2, 16'h0000);
        wait_idle();
        // Columns dropped by a smaller count keep their keys held.
        write_register(CFG_COL_COUNT, 5'd4);
        send_sample(3'd2, 16'hFFFF);
        wait_idle();
        write_register(CFG_COL_COUNT, 5'd16);
        send_sample(3'd2, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_spare_index();
        write_register(CFG_IDX_SPARE_LO, 5'd1);
        write_register(CFG_IDX_SPARE_HI, 5'd3);
        send_sample(3'd6, 16'h0000);
        send_sample(3'd6, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [CFG_DAT_W-1:0] rows_cfg;
        logic [CFG_DAT_W-1:0] cols_cfg;
        logic [ROW_W-1:0]     row;
        logic [MAP_W-1:0]     levels;
        int                   rows_used;
        int                   counted;
        int                   mode;
        int                   col;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin rows_cfg = 5'd8;  cols_cfg = 5'd16; end
                1: begin rows_cfg = 5'd1;  cols_cfg = 5'd16; end
                2: begin rows_cfg = 5'd8;  cols_cfg = 5'd1;  end
                3: begin rows_cfg = 5'h1F; cols_cfg = 5'd31; end
                default: begin
                    rows_cfg = CFG_DAT_W'($urandom_range(1, 31));
                    cols_cfg = CFG_DAT_W'($urandom_range(1, 31));
                    if (rows_cfg[ROW_CNT_W-1:0] == 0)
                        rows_cfg[0] = 1'b1;
                end
            endcase
            write_register(CFG_ROW_COUNT, rows_cfg);
            write_register(CFG_COL_COUNT, cols_cfg);
            if ($urandom_range(0, 2) == 0)
                write_register(CFG_IDX_W'($urandom_range(2, 15)),
                               CFG_DAT_W'($urandom_range(0, 31)));
            steady    = (phase == 2 || phase == 5);
            rows_used = (rows_cfg[ROW_CNT_W-1:0] < NUM_ROWS) ?
                        int'(rows_cfg[ROW_CNT_W-1:0]) : NUM_ROWS;
            counted   = 0;
            while (counted < RANDOM_ITEMS / RANDOM_PHASES) begin
                if ($urandom_range(0, 9) < 8)
                    row = ROW_W'($urandom_range(0, rows_used - 1));
                else
                    row = ROW_W'($urandom_range(0, NUM_ROWS - 1));
                mode = $urandom_range(0, 9);
                if (mode <= 5) begin
                    // Typical typing: up to three keys change state.
                    levels = ~held_keys[row];
                    repeat ($urandom_range(1, 3)) begin
                        col = $urandom_range(0, NUM_COLS - 1);
                        levels[col] = ~levels[col];
                    end
                end else if (mode == 6) begin
                    levels = ~held_keys[row];
                end else if (mode <= 8) begin
                    levels = MAP_W'($urandom_range(0, 16'hFFFF));
                end else begin
                    levels = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                send_sample(row, levels);
                if (row < rows_used)
                    counted++;
            end
            wait_idle();
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n                = 1'b0;
        sample_ch.valid      = 1'b0;
        sample_ch.row_index  = '0;
        sample_ch.col_levels = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        row_count_reg        = ROW_COUNT_RST;
        col_count_reg        = COL_COUNT_RST;
        for (int r = 0; r < NUM_ROWS; r++)
            held_keys[r] = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_default_scan();
        test_row_count();
        test_col_count();
        test_spare_index();
        test_random_traffic();

        if (mismatches == 0 && expected_key_events.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
